FILE: design/vp_pkg.sv
package vp_pkg;

  // Projection modes held in proj_select. The unused code behaves as isometric.
  localparam logic [1:0] MODE_ISO   = 2'd0;
  localparam logic [1:0] MODE_CAV   = 2'd1;
  localparam logic [1:0] MODE_PERSP = 2'd2;

  // Register indexes; register i sits at byte address 4*i.
  localparam int ADDR_BITS = 5;
  localparam logic [2:0] REG_PROJ_SELECT   = 3'd0;
  localparam logic [2:0] REG_PLANE_Z       = 3'd1;
  localparam logic [2:0] REG_EYE_Z         = 3'd2;
  localparam logic [2:0] REG_SCREEN_OFFSET = 3'd3;
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd4;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd5;

  localparam logic [1:0]  RST_PROJ_SELECT   = MODE_ISO;
  localparam logic [15:0] RST_PLANE_Z       = 16'd1600;
  localparam logic [15:0] RST_EYE_Z         = 16'd8000;
  localparam logic [11:0] RST_SCREEN_OFFSET = 12'd200;
  localparam logic [11:0] RST_CANVAS_WIDTH  = 12'd640;
  localparam logic [11:0] RST_CANVAS_HEIGHT = 12'd480;

  // cos 45, sin 45, sin 35.26, cos 35.26 at 30 fraction bits.
  localparam logic [63:0] Q30_CA = 64'd759250135;
  localparam logic [63:0] Q30_SA = 64'd759250115;
  localparam logic [63:0] Q30_SB = 64'd619857961;
  localparam logic [63:0] Q30_CB = 64'd876754021;

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + (64'd1 << 29);
    return p >> 30;
  endfunction

  function automatic logic [63:0] coef_round(input logic [63:0] q30, input int frac);
    logic [63:0] t;
    t = q30 + (64'd1 << (29 - frac));
    return t >> (30 - frac);
  endfunction

endpackage

FILE: design/vp_in_if.sv
interface vp_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source(output valid, output point_x, output point_y, output point_z, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

FILE: design/vp_out_if.sv
interface vp_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] screen_x;
  logic        [11:0] screen_y;
  logic signed [15:0] depth;
  logic               off_canvas;

  modport source(output valid, output screen_x, output screen_y, output depth,
                 output off_canvas, input ready);
  modport sink(input valid, input screen_x, input screen_y, input depth,
               input off_canvas, output ready);
endinterface

FILE: design/vertex_projection_core.sv
// Vertex projection core. Takes one signed vertex per cycle unless the skid entry is full,
// and returns one screen-space result per vertex, in order. The pipeline depth is set by the
// perspective divider, a restoring long division that resolves one quotient bit per pipeline
// stage; all three modes take the same path so results never reorder. A two-entry output
// register and skid stage let a beat be taken at the input while a finished result waits.
// The user must write the registers through the APB port only while the core is idle; the
// core itself does not enforce this.
module vertex_projection_core #(
  parameter int COORD_BITS     = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  vp_in_if.sink                       vin,
  vp_out_if.source                    vout,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vp_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = COEF_FRAC_BITS;
  localparam int KB  = F + 2;
  localparam int PB  = CB + KB;
  localparam int SB  = PB + 2;
  localparam int UB  = SB - F;
  localparam int NB  = CB + 2;
  localparam int DB  = CB + 1;
  localparam int PWB = CB + NB;
  localparam int MB  = 2 * CB + 1;
  localparam int AB  = MB + 1;
  localparam int XB  = ((AB + 1) > 42 ? (AB + 1) : 42) + 1;

  localparam logic signed [KB-1:0] CA   = KB'(coef_round(Q30_CA, F));
  localparam logic signed [KB-1:0] SA   = KB'(coef_round(Q30_SA, F));
  localparam logic signed [KB-1:0] SBC  = KB'(coef_round(Q30_SB, F));
  localparam logic signed [KB-1:0] CBC  = KB'(coef_round(Q30_CB, F));
  localparam logic signed [KB-1:0] SACB = KB'(coef_round(q30_mul(Q30_SA, Q30_CB), F));
  localparam logic signed [KB-1:0] CACB = KB'(coef_round(q30_mul(Q30_CA, Q30_CB), F));
  localparam logic signed [KB-1:0] SASB = KB'(coef_round(q30_mul(Q30_SA, Q30_SB), F));
  localparam logic signed [KB-1:0] CASB = KB'(coef_round(q30_mul(Q30_CA, Q30_SB), F));
  localparam logic signed [KB-1:0] ONE  = KB'(64'd1 << F);
  localparam logic signed [KB-1:0] ZERO = '0;
  localparam logic signed [SB-1:0] HALF = SB'(64'd1 << (F - 1));

  localparam logic signed [UB-1:0] U_MAX = UB'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [UB-1:0] U_MIN = -UB'(64'd1 << (CB - 1));
  localparam logic signed [UB-1:0] W_MAX = UB'(32767);
  localparam logic signed [UB-1:0] W_MIN = -UB'(32768);
  localparam logic signed [XB-1:0] R_MAX = XB'(64'd1 << 40);
  localparam logic signed [XB-1:0] R_MIN = -XB'(64'd1 << 40);

  // ---------------- configuration ----------------
  logic [1:0]  proj_select;
  logic [15:0] plane_z;
  logic [15:0] eye_z;
  logic [11:0] screen_offset;
  logic [11:0] canvas_width;
  logic [11:0] canvas_height;
  logic [2:0]  reg_index;
  logic        wr;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1:2];
  assign wr        = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_select   <= RST_PROJ_SELECT;
      plane_z       <= RST_PLANE_Z;
      eye_z         <= RST_EYE_Z;
      screen_offset <= RST_SCREEN_OFFSET;
      canvas_width  <= RST_CANVAS_WIDTH;
      canvas_height <= RST_CANVAS_HEIGHT;
    end else if (wr) begin
      case (reg_index)
        REG_PROJ_SELECT:   proj_select   <= pwdata[1:0];
        REG_PLANE_Z:       plane_z       <= pwdata[15:0];
        REG_EYE_Z:         eye_z         <= pwdata[15:0];
        REG_SCREEN_OFFSET: screen_offset <= pwdata[11:0];
        REG_CANVAS_WIDTH:  canvas_width  <= pwdata[11:0];
        REG_CANVAS_HEIGHT: canvas_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PROJ_SELECT:   prdata = {30'd0, proj_select};
      REG_PLANE_Z:       prdata = {16'd0, plane_z};
      REG_EYE_Z:         prdata = {16'd0, eye_z};
      REG_SCREEN_OFFSET: prdata = {20'd0, screen_offset};
      REG_CANVAS_WIDTH:  prdata = {20'd0, canvas_width};
      REG_CANVAS_HEIGHT: prdata = {20'd0, canvas_height};
      default:           prdata = '0;
    endcase
  end

  logic is_cav;
  logic is_persp;
  assign is_cav   = (proj_select == MODE_CAV);
  assign is_persp = (proj_select == MODE_PERSP);

  // The depth registers are taken as CB-bit signed fields.
  logic        [CB-1:0] eye_field;
  logic        [CB-1:0] plane_field;
  logic signed [NB-1:0] eye_ext;
  logic signed [NB-1:0] plane_ext;
  assign eye_field   = CB'({{CB{1'b0}}, eye_z});
  assign plane_field = CB'({{CB{1'b0}}, plane_z});
  assign eye_ext     = $signed({{2{eye_field[CB-1]}}, eye_field});
  assign plane_ext   = $signed({{2{plane_field[CB-1]}}, plane_field});

  // ---------------- flow control ----------------
  logic en;
  logic skid_valid;
  assign en        = !skid_valid;
  assign vin.ready = en;

  // ---------------- stage 0: input register ----------------
  logic                 v0;
  logic signed [CB-1:0] s0_x, s0_y, s0_z;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= vin.valid;
    if (en) begin
      s0_x <= vin.point_x;
      s0_y <= vin.point_y;
      s0_z <= vin.point_z;
    end
  end

  // ---------------- stage 1: nine products ----------------
  logic signed [KB-1:0] c [9];
  logic signed [NB-1:0] den_full;

  always_comb begin
    if (is_cav) begin
      c[0] = ONE;  c[1] = ZERO; c[2] = -CA;
      c[3] = ZERO; c[4] = ONE;  c[5] = -SA;
      c[6] = ZERO; c[7] = ZERO; c[8] = ONE;
    end else begin
      c[0] = CA;   c[1] = -SA;  c[2] = ZERO;
      c[3] = SACB; c[4] = CACB; c[5] = -SBC;
      c[6] = SASB; c[7] = CASB; c[8] = CBC;
    end
  end

  assign den_full = eye_ext - NB'(s0_z);

  logic                 v1;
  logic signed [PB-1:0] s1_p [9];
  logic signed [NB-1:0] s1_den;
  logic signed [NB-1:0] s1_num;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[3*i]   <= PB'(s0_x) * PB'(c[3*i]);
        s1_p[3*i+1] <= PB'(s0_y) * PB'(c[3*i+1]);
        s1_p[3*i+2] <= PB'(s0_z) * PB'(c[3*i+2]);
      end
      s1_den <= den_full;
      s1_num <= eye_ext - plane_ext;
    end
  end

  // ---------------- stage 2: sums and rounding ----------------
  logic signed [SB-1:0] sum_u, sum_v, sum_w;
  logic signed [UB-1:0] u_lin, v_lin, w_lin;

  assign sum_u = SB'(s1_p[0]) + SB'(s1_p[1]) + SB'(s1_p[2]) + HALF;
  assign sum_v = SB'(s1_p[3]) + SB'(s1_p[4]) + SB'(s1_p[5]) + HALF;
  assign sum_w = SB'(s1_p[6]) + SB'(s1_p[7]) + SB'(s1_p[8]) + HALF;
  assign u_lin = sum_u[SB-1:F];
  assign v_lin = sum_v[SB-1:F];
  assign w_lin = sum_w[SB-1:F];

  logic                 v2;
  logic signed [UB-1:0] s2_u, s2_v;
  logic signed [CB-1:0] s2_us, s2_vs;
  logic signed [15:0]   s2_depth;
  logic signed [NB-1:0] s2_den;
  logic signed [NB-1:0] s2_num;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2_u     <= u_lin;
      s2_v     <= v_lin;
      s2_us    <= (u_lin > U_MAX) ? U_MAX[CB-1:0] : ((u_lin < U_MIN) ? U_MIN[CB-1:0] : u_lin[CB-1:0]);
      s2_vs    <= (v_lin > U_MAX) ? U_MAX[CB-1:0] : ((v_lin < U_MIN) ? U_MIN[CB-1:0] : v_lin[CB-1:0]);
      s2_depth <= (w_lin > W_MAX) ? W_MAX[15:0] : ((w_lin < W_MIN) ? W_MIN[15:0] : w_lin[15:0]);
      s2_den   <= s1_den;
      s2_num   <= s1_num;
    end
  end

  // ---------------- stage 3: perspective numerators ----------------
  logic                  v3;
  logic signed [PWB-1:0] s3_pu, s3_pv;
  logic signed [UB-1:0]  s3_u, s3_v;
  logic signed [15:0]    s3_depth;
  logic        [DB-1:0]  s3_den;
  logic                  s3_bad;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      s3_pu    <= PWB'(s2_us) * PWB'(s2_num);
      s3_pv    <= PWB'(s2_vs) * PWB'(s2_num);
      s3_u     <= s2_u;
      s3_v     <= s2_v;
      s3_depth <= s2_depth;
      s3_den   <= s2_den[DB-1:0];
      s3_bad   <= (s2_den <= 0);
    end
  end

  // ---------------- stage 4 and divider stages ----------------
  typedef struct packed {
    logic        [AB-1:0] aq_u;
    logic        [DB-1:0] rem_u;
    logic        [AB-1:0] aq_v;
    logic        [DB-1:0] rem_v;
    logic        [DB-1:0] den;
    logic                 neg_u;
    logic                 neg_v;
    logic signed [UB-1:0] lin_u;
    logic signed [UB-1:0] lin_v;
    logic signed [15:0]   depth;
    logic                 bad;
  } div_t;

  div_t        dp [AB+1];
  logic [AB:0] dv;

  logic [PWB-1:0] mag_u, mag_v;
  assign mag_u = s3_pu[PWB-1] ? -s3_pu : s3_pu;
  assign mag_v = s3_pv[PWB-1] ? -s3_pv : s3_pv;

  // The rounding half of the divisor is folded into the dividend.
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v3;
    if (en) begin
      dp[0].aq_u  <= AB'(mag_u[MB-1:0]) + AB'(s3_den >> 1);
      dp[0].aq_v  <= AB'(mag_v[MB-1:0]) + AB'(s3_den >> 1);
      dp[0].rem_u <= '0;
      dp[0].rem_v <= '0;
      dp[0].den   <= s3_den;
      dp[0].neg_u <= s3_pu[PWB-1];
      dp[0].neg_v <= s3_pv[PWB-1];
      dp[0].lin_u <= s3_u;
      dp[0].lin_v <= s3_v;
      dp[0].depth <= s3_depth;
      dp[0].bad   <= s3_bad;
    end
  end

  for (genvar k = 1; k <= AB; k++) begin : g_div
    logic [DB:0] tr_u, tr_v, sub_u, sub_v;
    logic        ge_u, ge_v;
    div_t        nx;

    always_comb begin
      tr_u  = {dp[k-1].rem_u, dp[k-1].aq_u[AB-1]};
      tr_v  = {dp[k-1].rem_v, dp[k-1].aq_v[AB-1]};
      sub_u = tr_u - {1'b0, dp[k-1].den};
      sub_v = tr_v - {1'b0, dp[k-1].den};
      ge_u  = (tr_u >= {1'b0, dp[k-1].den});
      ge_v  = (tr_v >= {1'b0, dp[k-1].den});
      nx       = dp[k-1];
      nx.aq_u  = {dp[k-1].aq_u[AB-2:0], ge_u};
      nx.aq_v  = {dp[k-1].aq_v[AB-2:0], ge_v};
      nx.rem_u = ge_u ? sub_u[DB-1:0] : tr_u[DB-1:0];
      nx.rem_v = ge_v ? sub_v[DB-1:0] : tr_v[DB-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else if (en) dv[k] <= dv[k-1];
      if (en) dp[k] <= nx;
    end
  end

  // ---------------- final stage 1: select and clamp ----------------
  logic signed [XB-1:0] qu, qv, ru_sel, rv_sel;

  always_comb begin
    qu = XB'({1'b0, dp[AB].aq_u});
    qv = XB'({1'b0, dp[AB].aq_v});
    if (dp[AB].neg_u) qu = -qu;
    if (dp[AB].neg_v) qv = -qv;
    if (!is_persp) begin
      qu = XB'(dp[AB].lin_u);
      qv = XB'(dp[AB].lin_v);
    end
    ru_sel = (qu > R_MAX) ? R_MAX : ((qu < R_MIN) ? R_MIN : qu);
    rv_sel = (qv > R_MAX) ? R_MAX : ((qv < R_MIN) ? R_MIN : qv);
  end

  logic                 vf;
  logic signed [XB-1:0] f_u, f_v;
  logic signed [15:0]   f_depth;
  logic                 f_bad;

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= dv[AB];
    if (en) begin
      f_u     <= ru_sel;
      f_v     <= rv_sel;
      f_depth <= dp[AB].depth;
      f_bad   <= is_persp && dp[AB].bad;
    end
  end

  // ---------------- final stage 2: offset, canvas test, pixel ----------------
  logic signed [XB-1:0] ru, rv;
  logic signed [XB-1:0] lim_x, lim_y;
  logic        [11:0]   px, py;
  logic                 outside;

  assign ru    = f_u + XB'({screen_offset, 4'd0});
  assign rv    = f_v + XB'({screen_offset, 4'd0});
  assign lim_x = XB'({canvas_width, 4'd0});
  assign lim_y = XB'({canvas_height, 4'd0});

  always_comb begin
    outside = (ru < 0) || (ru > lim_x) || (rv < 0) || (rv > lim_y);
    if (ru < 0) px = '0;
    else if (ru[XB-1:4] > (XB-4)'(4095)) px = 12'hFFF;
    else px = ru[15:4];
    if (rv < 0) py = '0;
    else if (rv[XB-1:4] > (XB-4)'(4095)) py = 12'hFFF;
    else py = rv[15:4];
    if (f_bad) begin
      px = '0;
      py = '0;
    end
  end

  typedef struct packed {
    logic        [11:0] sx;
    logic        [11:0] sy;
    logic signed [15:0] depth;
    logic               flag;
  } res_t;

  res_t res_new, out_r, skid_r;
  logic out_valid;
  logic take;

  assign res_new = '{sx: px, sy: py, depth: f_depth, flag: f_bad || outside};
  assign take    = out_valid && vout.ready;

  // The skid entry catches a beat that leaves the pipe while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_r      <= skid_r;
        skid_valid <= 1'b0;
      end
    end else if (vf) begin
      if (!out_valid || take) begin
        out_r     <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_r     <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign vout.valid      = out_valid;
  assign vout.screen_x   = out_r.sx;
  assign vout.screen_y   = out_r.sy;
  assign vout.depth      = out_r.depth;
  assign vout.off_canvas = out_r.flag;

endmodule

FILE: design/vp_checker.sv
module vp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [11:0]                  screen_x,
  input logic [11:0]                  screen_y,
  input logic [15:0]                  depth,
  input logic                         off_canvas,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [vp_pkg::ADDR_BITS-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata
);
  import vp_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({screen_x, screen_y, depth, off_canvas}))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("core not empty after reset");

  // The input only stalls when a finished result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[ADDR_BITS-1:2] == REG_PROJ_SELECT)
      ##1 (paddr[ADDR_BITS-1:2] == REG_PROJ_SELECT)
      |-> prdata[1:0] == $past(pwdata[1:0]))
    else $error("projection mode readback mismatch");

endmodule

bind vertex_projection_core vp_checker u_vp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (vin.valid),
  .in_ready   (vin.ready),
  .out_valid  (vout.valid),
  .out_ready  (vout.ready),
  .screen_x   (vout.screen_x),
  .screen_y   (vout.screen_y),
  .depth      (vout.depth),
  .off_canvas (vout.off_canvas),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

FILE: test/vertex_projection_core_test.sv
module vertex_projection_core_test;
  import vp_pkg::*;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } vertex_t;

  typedef struct packed {
    logic [11:0]        sx;
    logic [11:0]        sy;
    logic signed [15:0] depth;
    logic               off;
  } pixel_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;

  vp_in_if  vin();
  vp_out_if vout();

  vertex_projection_core dut (
    .clk(clk), .rst(rst), .vin(vin), .vout(vout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the register file.
  logic [1:0]  mode_q;
  logic [15:0] plane_q, eye_q;
  logic [11:0] offset_q, width_q, height_q;

  vertex_t pending_vertices[$];
  pixel_t  expected_pixels[$];
  int      failures;
  bit      idle_enable;
  int      hold_off;
  longint  cycle_count;
  bit      in_taken;

  localparam longint CYCLE_LIMIT = 400000;

  // Projection coefficients at 15 fraction bits.
  longint k_ca, k_sa, k_sb, k_cb, k_sacb, k_cacb, k_sasb, k_casb;

  function automatic longint round_shift(longint v);
    longint t;
    t = v + (64'sd1 <<< 14);
    return t >>> 15;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint scale_persp(longint v, longint num, longint den);
    longint p, m, q;
    v = clamp(v, -32768, 32767);
    p = v * num;
    m = p < 0 ? -p : p;
    q = (m + den / 2) / den;
    return p < 0 ? -q : q;
  endfunction

  function automatic logic [11:0] to_pixel(longint raw);
    if (raw < 0) return 12'd0;
    raw = raw >>> 4;
    return raw > 4095 ? 12'd4095 : raw[11:0];
  endfunction

  function automatic pixel_t project_vertex(vertex_t vx);
    longint x, y, z, u, v, w, den, num, ru, rv, offs;
    pixel_t r;
    x = vx.px;
    y = vx.py;
    z = vx.pz;
    r.off = 1'b0;
    if (mode_q == MODE_CAV) begin
      u = round_shift(x * 32768 - k_ca * z);
      v = round_shift(y * 32768 - k_sa * z);
      w = z;
    end else begin
      u = round_shift(k_ca * x - k_sa * y);
      v = round_shift(k_sacb * x + k_cacb * y - k_sb * z);
      w = round_shift(k_sasb * x + k_casb * y + k_cb * z);
    end
    if (mode_q == MODE_PERSP) begin
      den = longint'($signed(eye_q)) - z;
      num = longint'($signed(eye_q)) - longint'($signed(plane_q));
      if (den <= 0) begin
        r.off = 1'b1;
      end else begin
        u = scale_persp(u, num, den);
        v = scale_persp(v, num, den);
      end
    end
    if (r.off) begin
      r.sx = '0;
      r.sy = '0;
    end else begin
      offs = longint'(offset_q) * 16;
      ru = clamp(u, -(64'sd1 <<< 40), 64'sd1 <<< 40) + offs;
      rv = clamp(v, -(64'sd1 <<< 40), 64'sd1 <<< 40) + offs;
      if (ru < 0 || ru > longint'(width_q) * 16 || rv < 0 || rv > longint'(height_q) * 16)
        r.off = 1'b1;
      r.sx = to_pixel(ru);
      r.sy = to_pixel(rv);
    end
    r.depth = 16'(clamp(w, -32768, 32767));
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Input beats are taken at the rising edge, so predictions are made there.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= vin.valid && vin.ready;
      if (vin.valid && vin.ready)
        expected_pixels.push_back(project_vertex(pending_vertices.pop_front()));
    end
  end

  // Sender: offers the head of the queue, with random idle bursts.
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      vin.valid <= 1'b0;
      send_gap  <= 0;
    end else if (vin.valid && !in_taken) begin
      // An offered beat stays on the bus until it is taken.
      vin.valid <= 1'b1;
    end else begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        vin.valid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 19) == 0) begin
        send_gap  <= $urandom_range(0, 15);
        vin.valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vin.valid   <= 1'b1;
        vin.point_x <= pending_vertices[0].px;
        vin.point_y <= pending_vertices[0].py;
        vin.point_z <= pending_vertices[0].pz;
      end else begin
        vin.valid <= 1'b0;
      end
    end
  end

  // Receiver stall control, including the long hold-off.
  int recv_gap;
  always @(negedge clk) begin
    if (rst) begin
      vout.ready <= 1'b0;
      recv_gap   <= 0;
    end else if (hold_off > 0) begin
      hold_off   <= hold_off - 1;
      vout.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      vout.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 19) == 0) begin
      recv_gap   <= $urandom_range(0, 15);
      vout.ready <= 1'b0;
    end else begin
      vout.ready <= 1'b1;
    end
  end

  // Checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && vout.valid && vout.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result beat with no vertex outstanding");
        failures++;
      end else begin
        e = expected_pixels.pop_front();
        if (vout.screen_x !== e.sx) begin
          $error("screen_x expected %0d got %0d", e.sx, vout.screen_x);
          failures++;
        end
        if (vout.screen_y !== e.sy) begin
          $error("screen_y expected %0d got %0d", e.sy, vout.screen_y);
          failures++;
        end
        if (vout.depth !== e.depth) begin
          $error("depth expected %0d got %0d", e.depth, vout.depth);
          failures++;
        end
        if (vout.off_canvas !== e.off) begin
          $error("off_canvas expected %0d got %0d", e.off, vout.off_canvas);
          failures++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PROJ_SELECT:   mode_q   = val[1:0];
      REG_PLANE_Z:       plane_q  = val[15:0];
      REG_EYE_Z:         eye_q    = val[15:0];
      REG_SCREEN_OFFSET: offset_q = val[11:0];
      REG_CANVAS_WIDTH:  width_q  = val[11:0];
      REG_CANVAS_HEIGHT: height_q = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || expected_pixels.size() > 0 || vin.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    vertex_t v;
    v.px = x;
    v.py = y;
    v.pz = z;
    pending_vertices.push_back(v);
  endtask

  // Mostly small coordinates that land near the canvas, some full range.
  task automatic add_random(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 3);
      if (sel == 0)
        add_vertex(16'($urandom), 16'($urandom), 16'($urandom));
      else
        add_vertex(16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 8191) - 4096),
                   16'($urandom_range(0, 16383) - 8192));
    end
  endtask

  initial begin
    logic [15:0] edge_vals[5];
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    k_ca   = coef_round(Q30_CA, 15);
    k_sa   = coef_round(Q30_SA, 15);
    k_sb   = coef_round(Q30_SB, 15);
    k_cb   = coef_round(Q30_CB, 15);
    k_sacb = coef_round(q30_mul(Q30_SA, Q30_CB), 15);
    k_cacb = coef_round(q30_mul(Q30_CA, Q30_CB), 15);
    k_sasb = coef_round(q30_mul(Q30_SA, Q30_SB), 15);
    k_casb = coef_round(q30_mul(Q30_CA, Q30_SB), 15);
    mode_q   = RST_PROJ_SELECT;
    plane_q  = RST_PLANE_Z;
    eye_q    = RST_EYE_Z;
    offset_q = RST_SCREEN_OFFSET;
    width_q  = RST_CANVAS_WIDTH;
    height_q = RST_CANVAS_HEIGHT;
    failures = 0;
    idle_enable = 1'b1;
    hold_off = 0;
    cycle_count = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vin.valid = 1'b0;
    vin.point_x = '0;
    vin.point_y = '0;
    vin.point_z = '0;
    vout.ready = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes under reset settings, then each mode.
    for (int i = 0; i < 5; i++) add_vertex(edge_vals[i], edge_vals[4 - i], edge_vals[i]);
    add_vertex(16'h0000, 16'h0000, 16'h0000);
    drain();
    for (int m = 1; m < 4; m++) begin
      reg_write(REG_PROJ_SELECT, m);
      add_vertex(16'h7fff, 16'h8000, 16'h7fff);
      add_vertex(16'h0100, 16'hff00, 16'h1f40);  // z equal to eye: zero denominator
      add_vertex(16'h0100, 16'h0200, 16'h8000);
      add_vertex(16'hff00, 16'h0100, 16'h0010);
      drain();
    end
    // Zero-size canvas: only a sum of exactly zero stays inside.
    reg_write(REG_PROJ_SELECT, 32'(MODE_CAV));
    reg_write(REG_SCREEN_OFFSET, 0);
    reg_write(REG_CANVAS_WIDTH, 0);
    reg_write(REG_CANVAS_HEIGHT, 0);
    add_vertex(16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0001, 16'h0000, 16'h0000);
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      reg_write(REG_PROJ_SELECT, ph % 4);
      case (ph % 3)
        0: begin
          reg_write(REG_PLANE_Z, $urandom_range(0, 4000));
          reg_write(REG_EYE_Z, $urandom_range(4000, 32767));
        end
        1: begin
          reg_write(REG_PLANE_Z, ph[2] ? 32'h0000_8000 : 32'h0000_7fff);
          reg_write(REG_EYE_Z, ph[2] ? 32'h0000_7fff : 32'h0000_8000);
        end
        default: begin
          reg_write(REG_PLANE_Z, $urandom);
          reg_write(REG_EYE_Z, $urandom);
        end
      endcase
      reg_write(REG_SCREEN_OFFSET, ph == 5 ? 4095 : $urandom_range(0, 600));
      reg_write(REG_CANVAS_WIDTH, ph == 7 ? 4095 : $urandom_range(1, 1200));
      reg_write(REG_CANVAS_HEIGHT, ph == 7 ? 4095 : $urandom_range(1, 1200));
      if (ph == 3) hold_off = 300;
      if (ph == 11) idle_enable = 1'b0;
      add_random(160);
      drain();
    end

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
